// ===== rtl/dds_pkg.sv =====
// Package for the delimiter depth scanner: request types, mode codes, character codes and depth helpers.
`timescale 1ns / 1ps

package dds_pkg;

  // Width of the internal brace and parenthesis depth counters.
  localparam int DEPTH_BITS = 8;
  localparam int OUT_BITS   = 8;
  localparam int WIDE_BITS  = (DEPTH_BITS > OUT_BITS) ? DEPTH_BITS : OUT_BITS;

  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_ZERO = '0;

  localparam logic signed [WIDE_BITS-1:0] OUT_MAX_W = WIDE_BITS'(127);
  localparam logic signed [WIDE_BITS-1:0] OUT_MIN_W = -WIDE_BITS'(128);

  // Action codes.
  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_STRING = 3'd1,
    MODE_CHAR   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_LINE   = 3'd4
  } scan_mode_t;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } src_item_t;

  typedef struct packed {
    logic              incomplete;
    logic signed [7:0] brace_depth_out;
    logic signed [7:0] paren_depth_out;
    logic              inside_string;
    logic              inside_char;
    logic              inside_comment;
  } res_item_t;

  // Control passed from the top level to the scanner core.
  typedef struct packed {
    logic      fire;
    src_item_t item;
  } scan_ctrl_t;

  function automatic logic signed [DEPTH_BITS-1:0] sat_inc(
      input logic signed [DEPTH_BITS-1:0] v);
    return (v != DEPTH_MAX) ? v + DEPTH_BITS'(1) : v;
  endfunction

  function automatic logic signed [DEPTH_BITS-1:0] sat_dec(
      input logic signed [DEPTH_BITS-1:0] v);
    return (v != DEPTH_MIN) ? v - DEPTH_BITS'(1) : v;
  endfunction

  // Clamp a depth to the signed byte range of the result fields.
  function automatic logic signed [OUT_BITS-1:0] depth_field(
      input logic signed [DEPTH_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(v);
    if (w > OUT_MAX_W) begin
      w = OUT_MAX_W;
    end else if (w < OUT_MIN_W) begin
      w = OUT_MIN_W;
    end
    return w[OUT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/delimiter_depth_scanner.sv =====
// Top level of the delimiter depth scanner: input register, scanner core and result register.
//
//   Channel | Handshake             | Payload                 | Direction
//   --------+-----------------------+-------------------------+----------
//   source  | src_valid / src_ready | src_item (src_item_t)   | in
//   result  | res_valid / res_ready | res_item (res_item_t)   | out
//
// One request is taken per clock cycle when the result side keeps up, and each
// request yields exactly one result: it is held in the input register, where
// the scanner core evaluates it, and then in the result register. The
// throughput is set by the update of the core's mode and depth registers. A
// synchronous reset clears both valid flags and all scanner state. When
// res_ready is low the result register holds, the input register fills, and
// src_ready then drops until the result is taken.
`timescale 1ns / 1ps

module delimiter_depth_scanner (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  dds_pkg::src_item_t src_item,
  output logic               res_valid,
  input  logic               res_ready,
  output dds_pkg::res_item_t res_item
);

  // Input register holding the request that the core evaluates this cycle.
  logic               s1_valid;
  dds_pkg::src_item_t s1_item;

  // The held request moves on when the result register is free or emptying.
  logic advance;
  dds_pkg::scan_ctrl_t ctrl;
  dds_pkg::res_item_t  core_result;

  assign advance   = s1_valid && (!res_valid || res_ready);
  assign src_ready = !s1_valid || advance;

  assign ctrl.fire = advance;
  assign ctrl.item = s1_item;

  dds_scan_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_ready) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      s1_item <= src_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= core_result;
    end
  end

  // The source side only stalls when both registers are full and the result
  // is not being taken.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> (s1_valid && res_valid && !res_ready))
    else $error("source stalled without a full pipeline");

  // A request leaving the input register always lands in the result register.
  a_advance_lands : assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("advanced request did not reach the result register");

  // Only a line end can report an incomplete line.
  a_text_complete : assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.action == dds_pkg::ACT_TEXT) |=> !res_item.incomplete)
    else $error("text byte reported an incomplete line");

  // The string, literal and comment flags never overlap.
  a_one_mode : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_item.inside_string, res_item.inside_char,
                            res_item.inside_comment}))
    else $error("more than one scan mode reported");

endmodule

// ===== rtl/dds_scan_core.sv =====
// Scanner core: mode and depth state with the per-request update and result logic.
`timescale 1ns / 1ps

module dds_scan_core (
  input  logic                  clk,
  input  logic                  rst,
  input  dds_pkg::scan_ctrl_t   ctrl,
  output dds_pkg::res_item_t    result
);

  logic signed [dds_pkg::DEPTH_BITS-1:0] brace_count, brace_count_next;
  logic signed [dds_pkg::DEPTH_BITS-1:0] paren_count, paren_count_next;
  dds_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic slash_pending, slash_pending_next;
  logic star_pending, star_pending_next;
  logic escape_pending, escape_pending_next;
  logic last_was_backslash, last_was_backslash_next;

  logic [7:0] c;
  logic       eol_incomplete;
  logic [7:0] close_quote;

  assign c = ctrl.item.char_code;
  assign close_quote = (scan_mode == dds_pkg::MODE_STRING) ? dds_pkg::CH_DQUOTE
                                                           : dds_pkg::CH_SQUOTE;

  assign eol_incomplete = (brace_count > dds_pkg::DEPTH_ZERO) ||
                          (paren_count > dds_pkg::DEPTH_ZERO) ||
                          (scan_mode == dds_pkg::MODE_STRING) ||
                          (scan_mode == dds_pkg::MODE_CHAR) ||
                          (scan_mode == dds_pkg::MODE_BLOCK) ||
                          last_was_backslash;

  always_comb begin
    brace_count_next        = brace_count;
    paren_count_next        = paren_count;
    scan_mode_next          = scan_mode;
    slash_pending_next      = slash_pending;
    star_pending_next       = star_pending;
    escape_pending_next     = escape_pending;
    last_was_backslash_next = last_was_backslash;

    if (ctrl.item.action == dds_pkg::ACT_TEXT) begin
      last_was_backslash_next = (c == dds_pkg::CH_BACKSLASH);
      unique case (scan_mode)
        dds_pkg::MODE_BLOCK: begin
          if (star_pending && c == dds_pkg::CH_SLASH) begin
            scan_mode_next    = dds_pkg::MODE_NORMAL;
            star_pending_next = 1'b0;
          end else begin
            star_pending_next = (c == dds_pkg::CH_STAR);
          end
        end
        dds_pkg::MODE_STRING, dds_pkg::MODE_CHAR: begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
          end else if (c == dds_pkg::CH_BACKSLASH) begin
            escape_pending_next = 1'b1;
          end else if (c == close_quote) begin
            scan_mode_next = dds_pkg::MODE_NORMAL;
          end
        end
        dds_pkg::MODE_LINE: begin
        end
        default: begin
          // A pending slash followed by slash or star opens a comment and
          // consumes the byte; otherwise the byte is scanned as code.
          if (slash_pending && c == dds_pkg::CH_SLASH) begin
            slash_pending_next = 1'b0;
            scan_mode_next     = dds_pkg::MODE_LINE;
          end else if (slash_pending && c == dds_pkg::CH_STAR) begin
            slash_pending_next = 1'b0;
            scan_mode_next     = dds_pkg::MODE_BLOCK;
            star_pending_next  = 1'b0;
          end else begin
            slash_pending_next = 1'b0;
            priority if (c == dds_pkg::CH_SLASH) begin
              slash_pending_next = 1'b1;
            end else if (c == dds_pkg::CH_DQUOTE) begin
              scan_mode_next = dds_pkg::MODE_STRING;
            end else if (c == dds_pkg::CH_SQUOTE) begin
              scan_mode_next = dds_pkg::MODE_CHAR;
            end else if (c == dds_pkg::CH_LBRACE) begin
              brace_count_next = dds_pkg::sat_inc(brace_count);
            end else if (c == dds_pkg::CH_RBRACE) begin
              brace_count_next = dds_pkg::sat_dec(brace_count);
            end else if (c == dds_pkg::CH_LPAREN) begin
              paren_count_next = dds_pkg::sat_inc(paren_count);
            end else if (c == dds_pkg::CH_RPAREN) begin
              paren_count_next = dds_pkg::sat_dec(paren_count);
            end else begin
            end
          end
        end
      endcase
    end else begin
      slash_pending_next      = 1'b0;
      star_pending_next       = 1'b0;
      escape_pending_next     = 1'b0;
      last_was_backslash_next = 1'b0;
      if (scan_mode == dds_pkg::MODE_LINE) begin
        scan_mode_next = dds_pkg::MODE_NORMAL;
      end
      if (!eol_incomplete) begin
        brace_count_next = '0;
        paren_count_next = '0;
        scan_mode_next   = dds_pkg::MODE_NORMAL;
      end
    end
  end

  // A text byte reports the state after it; a line end reports the state
  // before any clearing.
  always_comb begin
    if (ctrl.item.action == dds_pkg::ACT_TEXT) begin
      result.incomplete      = 1'b0;
      result.brace_depth_out = dds_pkg::depth_field(brace_count_next);
      result.paren_depth_out = dds_pkg::depth_field(paren_count_next);
      result.inside_string   = (scan_mode_next == dds_pkg::MODE_STRING);
      result.inside_char     = (scan_mode_next == dds_pkg::MODE_CHAR);
      result.inside_comment  = (scan_mode_next == dds_pkg::MODE_BLOCK);
    end else begin
      result.incomplete      = eol_incomplete;
      result.brace_depth_out = dds_pkg::depth_field(brace_count);
      result.paren_depth_out = dds_pkg::depth_field(paren_count);
      result.inside_string   = (scan_mode == dds_pkg::MODE_STRING);
      result.inside_char     = (scan_mode == dds_pkg::MODE_CHAR);
      result.inside_comment  = (scan_mode == dds_pkg::MODE_BLOCK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brace_count        <= '0;
      paren_count        <= '0;
      scan_mode          <= dds_pkg::MODE_NORMAL;
      slash_pending      <= 1'b0;
      star_pending       <= 1'b0;
      escape_pending     <= 1'b0;
      last_was_backslash <= 1'b0;
    end else if (ctrl.fire) begin
      brace_count        <= brace_count_next;
      paren_count        <= paren_count_next;
      scan_mode          <= scan_mode_next;
      slash_pending      <= slash_pending_next;
      star_pending       <= star_pending_next;
      escape_pending     <= escape_pending_next;
      last_was_backslash <= last_was_backslash_next;
    end
  end

endmodule

// ===== sim/tb_delimiter_depth_scanner.sv =====
// Testbench for the delimiter depth scanner: directed and random source lines checked by a scanner predictor.
`timescale 1ns / 1ps

module tb_delimiter_depth_scanner;

  // Longest wait, in cycles, that either side may draw before a request.
  localparam int GAP_MAX = 13;
  // Settling wait after every owed result has come back; a comfortable margin.
  localparam int SETTLE_CYCLES = 8;
  // Size of the random part, and how often it pauses for the pipeline to drain.
  localparam int RANDOM_REQUESTS = 380;
  localparam int DRAIN_EVERY = 300;
  // Enough pushes to run either depth into its limit from zero, and twice that
  // to come back down to the other limit.
  localparam int SAT_PUSHES = 130;

  // Bytes that steer the scanner, drawn far more often than ordinary text.
  localparam logic [7:0] SYNTAX_BYTES [10] = '{
    dds_pkg::CH_LBRACE, dds_pkg::CH_RBRACE, dds_pkg::CH_LPAREN, dds_pkg::CH_RPAREN,
    dds_pkg::CH_SLASH, dds_pkg::CH_STAR, dds_pkg::CH_DQUOTE, dds_pkg::CH_SQUOTE,
    dds_pkg::CH_BACKSLASH, 8'h20
  };

  logic               clk;
  logic               rst;
  logic               src_valid;
  logic               src_ready;
  dds_pkg::src_item_t src_item;
  logic               res_valid;
  logic               res_ready;
  dds_pkg::res_item_t res_item;

  delimiter_depth_scanner DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // Predicted scanner state, kept in step with every accepted request.
  logic signed [dds_pkg::DEPTH_BITS-1:0] pred_brace;
  logic signed [dds_pkg::DEPTH_BITS-1:0] pred_paren;
  dds_pkg::scan_mode_t                   pred_mode;
  logic                                  pred_slash;
  logic                                  pred_star;
  logic                                  pred_escape;
  logic                                  pred_backslash;

  // Results still owed by the block, oldest first.
  dds_pkg::res_item_t pending_results[$];

  int mismatch_count;
  int stall_left;
  // While a quiet flag is set, that side takes no idle cycles at all.
  bit tx_quiet;
  bit rx_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung handshake must not hang the run. The slowest correct run is well
  // under a millisecond, so this leaves ample headroom.
  initial begin
    #10ms;
    $display("tb_delimiter_depth_scanner failed");
    $finish;
  end

  function automatic int draw_gap(bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  // The result fields are a signed byte, whatever the width of the counters.
  function automatic logic signed [7:0] clamp_depth(
      logic signed [dds_pkg::DEPTH_BITS-1:0] depth);
    int wide;
    wide = depth;
    if (wide > 127) begin
      return 8'sd127;
    end
    if (wide < -128) begin
      return -8'sd128;
    end
    return wide[7:0];
  endfunction

  task automatic clear_scan_state();
    pred_brace     = '0;
    pred_paren     = '0;
    pred_mode      = dds_pkg::MODE_NORMAL;
    pred_slash     = 1'b0;
    pred_star      = 1'b0;
    pred_escape    = 1'b0;
    pred_backslash = 1'b0;
  endtask

  // Advance the predicted state by one request and work out the result it
  // should produce.
  task automatic scan_predict(input dds_pkg::src_item_t req, output dds_pkg::res_item_t want);
    logic [7:0] ch;
    logic       opened;
    logic       open_line;
    ch     = req.char_code;
    opened = 1'b0;
    open_line = 1'b0;
    if (req.action == dds_pkg::ACT_TEXT) begin
      // A trailing backslash counts whatever mode the scanner is in.
      pred_backslash = (ch == dds_pkg::CH_BACKSLASH);
      case (pred_mode)
        dds_pkg::MODE_BLOCK: begin
          if (pred_star && ch == dds_pkg::CH_SLASH) begin
            pred_mode = dds_pkg::MODE_NORMAL;
            pred_star = 1'b0;
          end else begin
            pred_star = (ch == dds_pkg::CH_STAR);
          end
        end
        dds_pkg::MODE_STRING, dds_pkg::MODE_CHAR: begin
          if (pred_escape) begin
            pred_escape = 1'b0;
          end else if (ch == dds_pkg::CH_BACKSLASH) begin
            pred_escape = 1'b1;
          end else if (ch == ((pred_mode == dds_pkg::MODE_STRING) ? dds_pkg::CH_DQUOTE
                                                                  : dds_pkg::CH_SQUOTE)) begin
            pred_mode = dds_pkg::MODE_NORMAL;
          end
        end
        dds_pkg::MODE_LINE: begin
        end
        default: begin
          // A slash seen on the previous byte may open a comment here; if it
          // does not, this byte is treated as ordinary code.
          if (pred_slash) begin
            pred_slash = 1'b0;
            if (ch == dds_pkg::CH_SLASH) begin
              pred_mode = dds_pkg::MODE_LINE;
              opened    = 1'b1;
            end else if (ch == dds_pkg::CH_STAR) begin
              pred_mode = dds_pkg::MODE_BLOCK;
              pred_star = 1'b0;
              opened    = 1'b1;
            end
          end
          if (!opened) begin
            case (ch)
              dds_pkg::CH_SLASH:  pred_slash = 1'b1;
              dds_pkg::CH_DQUOTE: pred_mode  = dds_pkg::MODE_STRING;
              dds_pkg::CH_SQUOTE: pred_mode  = dds_pkg::MODE_CHAR;
              dds_pkg::CH_LBRACE:
                if (pred_brace != dds_pkg::DEPTH_MAX) pred_brace = pred_brace + 1'b1;
              dds_pkg::CH_RBRACE:
                if (pred_brace != dds_pkg::DEPTH_MIN) pred_brace = pred_brace - 1'b1;
              dds_pkg::CH_LPAREN:
                if (pred_paren != dds_pkg::DEPTH_MAX) pred_paren = pred_paren + 1'b1;
              dds_pkg::CH_RPAREN:
                if (pred_paren != dds_pkg::DEPTH_MIN) pred_paren = pred_paren - 1'b1;
              default: begin
              end
            endcase
          end
        end
      endcase
      want.incomplete = 1'b0;
    end else begin
      open_line = (pred_mode == dds_pkg::MODE_STRING) || (pred_mode == dds_pkg::MODE_CHAR) ||
                  (pred_mode == dds_pkg::MODE_BLOCK);
      want.incomplete = (pred_brace > 0) || (pred_paren > 0) || open_line || pred_backslash;
    end

    // The fields show the state before any end-of-line clearing.
    want.brace_depth_out = clamp_depth(pred_brace);
    want.paren_depth_out = clamp_depth(pred_paren);
    want.inside_string   = (pred_mode == dds_pkg::MODE_STRING);
    want.inside_char     = (pred_mode == dds_pkg::MODE_CHAR);
    want.inside_comment  = (pred_mode == dds_pkg::MODE_BLOCK);

    if (req.action == dds_pkg::ACT_EOL) begin
      // Look-ahead never reaches across a line end, and a line comment stops
      // there. A complete line starts the next one from scratch.
      pred_slash     = 1'b0;
      pred_star      = 1'b0;
      pred_escape    = 1'b0;
      pred_backslash = 1'b0;
      if (pred_mode == dds_pkg::MODE_LINE) begin
        pred_mode = dds_pkg::MODE_NORMAL;
      end
      if (!want.incomplete) begin
        clear_scan_state();
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic signed [7:0] got, logic signed [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Every accepted result is held against the oldest prediction. The receiver
  // draws its next stall at the same edge.
  always @(posedge clk) begin
    dds_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      stall_left = draw_gap(rx_quiet);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with nothing pending", res_item));
      end else begin
        want = pending_results.pop_front();
        check_field("incomplete", 8'(res_item.incomplete), 8'(want.incomplete));
        check_field("brace_depth_out", res_item.brace_depth_out, want.brace_depth_out);
        check_field("paren_depth_out", res_item.paren_depth_out, want.paren_depth_out);
        check_field("inside_string", 8'(res_item.inside_string), 8'(want.inside_string));
        check_field("inside_char", 8'(res_item.inside_char), 8'(want.inside_char));
        check_field("inside_comment", 8'(res_item.inside_comment),
                    8'(want.inside_comment));
      end
    end
  end

  // The receiver holds ready low for the drawn number of cycles after each
  // result, then keeps it high until the next one is taken.
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Offer one request after a drawn idle gap and hold it until it is taken.
  // The prediction is made at the accepting edge, before its result comes back.
  task automatic send_item(logic act, logic [7:0] code);
    dds_pkg::src_item_t req;
    dds_pkg::res_item_t want;
    int                 gap;
    req.action    = act;
    req.char_code = code;
    gap = draw_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= req;
    do @(posedge clk); while (!src_ready);
    scan_predict(req, want);
    pending_results = {pending_results, want};
  endtask

  // The byte that rides along with an end of line is meant to be ignored, so
  // it is random.
  task automatic send_eol();
    send_item(dds_pkg::ACT_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++) begin
      send_item(dds_pkg::ACT_TEXT, text[i]);
    end
  endtask

  // Stop sending and let every owed result come back before going on.
  task automatic wait_drained();
    @(negedge clk);
    src_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // An empty line, and the lowest and highest byte values as plain text.
  task automatic test_line_ends();
    send_eol();
    send_item(dds_pkg::ACT_TEXT, 8'h00);
    send_item(dds_pkg::ACT_TEXT, 8'hFF);
    send_eol();
  endtask

  // Open depth keeps a line incomplete; a negative depth does not.
  task automatic test_nesting();
    send_text("{(");
    send_eol();
    send_text(")}");
    send_eol();
    send_text("}");
    send_eol();
  endtask

  // Strings and character literals, with an escaped closing quote and an
  // escape that is cut off by the line end.
  task automatic test_quotes();
    send_text("\"\\\"");
    send_eol();
    send_text("\"");
    send_eol();
    send_text("'\\");
    send_eol();
    send_text("'");
    send_eol();
  endtask

  // A block comment across lines, where a star just before the line end must
  // not pair with a slash after it; a line comment hiding a brace; and a
  // slash just before the line end that must not pair with a star after it.
  task automatic test_comments();
    send_text("/*{*");
    send_eol();
    send_text("/*/");
    send_eol();
    send_text("(//{");
    send_eol();
    send_text("/");
    send_eol();
    send_text("*)");
    send_eol();
  endtask

  // A trailing backslash asks for more input even inside a line comment.
  task automatic test_trailing_backslash();
    send_text("\\");
    send_eol();
    send_text("//\\");
    send_eol();
    send_eol();
  endtask

  // Run both depths into the top of their range, then down into the bottom.
  task automatic test_depth_limits();
    repeat (SAT_PUSHES) send_item(dds_pkg::ACT_TEXT, dds_pkg::CH_LBRACE);
    repeat (SAT_PUSHES) send_item(dds_pkg::ACT_TEXT, dds_pkg::CH_LPAREN);
    send_eol();
    repeat (2 * SAT_PUSHES) send_item(dds_pkg::ACT_TEXT, dds_pkg::CH_RBRACE);
    repeat (2 * SAT_PUSHES) send_item(dds_pkg::ACT_TEXT, dds_pkg::CH_RPAREN);
    send_eol();
  endtask

  function automatic logic [7:0] pick_source_byte();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      return SYNTAX_BYTES[$urandom_range(0, 9)];
    end
    if (roll < 8) begin
      return 8'h61 + 8'($urandom_range(0, 25));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly lines of source-like text closed by a line end, with a sprinkling
  // of raw noise requests. Both sides drift in and out of quiet stretches.
  task automatic test_random_lines();
    int sent;
    int next_drain;
    sent       = 0;
    next_drain = DRAIN_EVERY;
    while (sent < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
      if ($urandom_range(0, 7) == 0) rx_quiet = !rx_quiet;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          sent++;
        end
      end else begin
        repeat ($urandom_range(0, 10)) begin
          send_item(dds_pkg::ACT_TEXT, pick_source_byte());
          sent++;
        end
        send_eol();
        sent++;
      end
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    src_valid      = 1'b0;
    src_item       = '0;
    res_ready      = 1'b0;
    mismatch_count = 0;
    stall_left     = 0;
    tx_quiet       = 1'b0;
    rx_quiet       = 1'b0;
    clear_scan_state();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_line_ends();
    test_nesting();
    wait_drained();
    test_quotes();
    test_comments();
    test_trailing_backslash();
    wait_drained();
    tx_quiet = 1'b1;
    test_depth_limits();
    tx_quiet = 1'b0;
    wait_drained();
    test_random_lines();
    wait_drained();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_delimiter_depth_scanner passed");
    end else begin
      $display("tb_delimiter_depth_scanner failed");
    end
    $finish;
  end

endmodule
